// ===== design/sct_pkg.sv =====
// Shared constants and helpers for the sphere contact test unit.
// No dependencies; used by every module of the block.

package sct_pkg;

    localparam int COORD_BITS  = 32;
    localparam int NORMAL_BITS = 16;
    localparam int TAG_BITS    = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic {
        t_op_sphere = 1'b0,
        t_op_plane  = 1'b1
    } t_op;

    // Width of one queue word between the front and the back.
    function automatic int qword_bits(input int cb, input int nb);
        return 1 + TAG_BITS + 3 * cb + (cb - 1) + 3 * (cb + 1) + (cb + 1) + cb + 3 * nb;
    endfunction

endpackage

// ===== design/sct_queue.sv =====
// Small first-in first-out queue that decouples the front from the back.
// Depends on sct_pkg for its depth.

module sct_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0]            r_mem [0:sct_pkg::QUEUE_DEPTH-1];
    logic [sct_pkg::QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [sct_pkg::QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [sct_pkg::QUEUE_AW:0]   r_count, n_count;
    logic                         push_ok;
    logic                         pop_ok;

    assign o_full  = (r_count == (sct_pkg::QUEUE_AW + 1)'(sct_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = push_ok ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop_ok ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/sct_front.sv =====
// Front end: takes a query word, forms centre offsets, the radius sum and the
// plane normal, and pushes the prepared word into the queue. Depends on sct_pkg.

module sct_front #(
    parameter int COORD_BITS  = sct_pkg::COORD_BITS,
    parameter int NORMAL_BITS = sct_pkg::NORMAL_BITS,
    parameter int QW          = sct_pkg::qword_bits(sct_pkg::COORD_BITS, sct_pkg::NORMAL_BITS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic [sct_pkg::TAG_BITS-1:0]  i_pair_tag,
    input  logic signed [COORD_BITS-1:0]  i_own_x,
    input  logic signed [COORD_BITS-1:0]  i_own_y,
    input  logic signed [COORD_BITS-1:0]  i_own_z,
    input  logic [COORD_BITS-2:0]         i_own_radius,
    input  logic signed [COORD_BITS-1:0]  i_other_x,
    input  logic signed [COORD_BITS-1:0]  i_other_y,
    input  logic signed [COORD_BITS-1:0]  i_other_z,
    input  logic signed [COORD_BITS-1:0]  i_other_size,
    input  logic                          i_full,
    output logic                          o_push,
    output logic [QW-1:0]                 o_word
);

    localparam int CB = COORD_BITS;
    localparam int NB = NORMAL_BITS;
    localparam int DW = CB + 1;

    typedef struct packed {
        logic                           op;
        logic [sct_pkg::TAG_BITS-1:0]   tag;
        logic [2:0][CB-1:0]             own;
        logic [CB-2:0]                  rad;
        logic [2:0][DW-1:0]             d;
        logic [DW-1:0]                  sum;
        logic [CB-1:0]                  size;
        logic [2:0][NB-1:0]             nrm;
    } t_qword;

    t_qword                r_word;
    t_qword                n_word;
    logic                  r_valid;
    logic                  load;
    logic [2:0][CB-1:0]    own;
    logic [2:0][CB-1:0]    oth;

    assign own     = {i_own_z, i_own_y, i_own_x};
    assign oth     = {i_other_z, i_other_y, i_other_x};
    assign o_stall = r_valid && i_full;
    assign load    = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;
    assign o_word  = QW'(r_word);

    always_comb begin
        n_word.op   = i_op;
        n_word.tag  = i_pair_tag;
        n_word.own  = own;
        n_word.rad  = i_own_radius;
        n_word.size = i_other_size;
        n_word.sum  = DW'($signed({2'b00, i_own_radius}) + $signed({i_other_size[CB-1],
                      i_other_size}));
        for (int i = 0; i < 3; i++) begin
            n_word.d[i] = DW'($signed({own[i][CB-1], own[i]}) - $signed({oth[i][CB-1],
                          oth[i]}));
            if (NB <= CB) begin
                n_word.nrm[i] = oth[i][NB-1:0];
            end else begin
                n_word.nrm[i] = NB'(oth[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= n_word;
        end
    end

endmodule

// ===== design/sct_back.sv =====
// Back end: squares, plane dot product, bit-per-stage square root and normal
// divider, and the result register. Depends on sct_pkg.

module sct_back #(
    parameter int COORD_BITS  = sct_pkg::COORD_BITS,
    parameter int NORMAL_BITS = sct_pkg::NORMAL_BITS,
    parameter int QW          = sct_pkg::qword_bits(sct_pkg::COORD_BITS, sct_pkg::NORMAL_BITS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  logic [QW-1:0]                 i_word,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sct_pkg::TAG_BITS-1:0]  o_contact_tag,
    output logic signed [NORMAL_BITS-1:0] o_normal_x,
    output logic signed [NORMAL_BITS-1:0] o_normal_y,
    output logic signed [NORMAL_BITS-1:0] o_normal_z,
    output logic [COORD_BITS:0]           o_depth
);

    localparam int CB  = COORD_BITS;
    localparam int NB  = NORMAL_BITS;
    localparam int NS  = NB - 2;
    localparam int DW  = CB + 1;
    localparam int SQW = 2 * DW + 2;
    localparam int RW  = DW + 1;
    localparam int RMW = RW + 2;
    localparam int DV  = RW + 1;
    localparam int QB  = NS + 2;
    localparam int PW  = CB + NB;
    localparam int TW  = CB + NB + 2;
    localparam int TTW = TW - NS + 1;
    localparam int DPW = CB + 1;
    localparam int TB  = sct_pkg::TAG_BITS;

    typedef struct packed {
        logic                 op;
        logic [TB-1:0]        tag;
        logic [2:0][CB-1:0]   own;
        logic [CB-2:0]        rad;
        logic [2:0][DW-1:0]   d;
        logic [DW-1:0]        sum;
        logic [CB-1:0]        size;
        logic [2:0][NB-1:0]   nrm;
    } t_qword;

    typedef struct packed {
        logic                 op;
        logic [TB-1:0]        tag;
        logic [2:0]           sgn;
        logic [2:0][DW-1:0]   mag;
        logic [DW-1:0]        sum;
        logic                 phit;
        logic [DPW-1:0]       pdepth;
        logic [2:0][NB-1:0]   nrm;
    } t_rpay;

    typedef struct packed {
        logic                 op;
        logic [TB-1:0]        tag;
        logic [2:0]           sgn;
        logic                 phit;
        logic [DPW-1:0]       pdepth;
        logic                 shit;
        logic [DPW-1:0]       sdepth;
        logic                 zl;
        logic [RW-1:0]        len;
        logic [2:0][NB-1:0]   nrm;
    } t_dpay;

    logic                 en;
    logic                 r_ov;

    t_qword               r_a;
    logic                 r_va;

    t_rpay                r_b_pay;
    logic [2:0][2*DW-1:0] r_b_sq;
    logic [2:0][PW-1:0]   r_b_prod;
    logic [CB-1:0]        r_b_size;
    logic [CB-2:0]        r_b_rad;
    logic                 r_vb;
    t_rpay                n_b_pay;
    logic [2:0][2*DW-1:0] n_b_sq;
    logic [2:0][PW-1:0]   n_b_prod;

    t_rpay                r_c_pay;
    logic [SQW-1:0]       r_c_sq;
    logic [TW-1:0]        r_c_acc;
    logic [CB-2:0]        r_c_rad;
    logic                 r_vc;
    logic [SQW-1:0]       n_c_sq;
    logic [TW-1:0]        n_c_acc;

    logic [TW-NS-1:0]     d_dist;
    logic [TTW-1:0]       d_t;
    t_rpay                n_d_pay;

    logic [SQW-1:0]       r_rt_rad  [0:RW];
    logic [RMW-1:0]       r_rt_rem  [0:RW];
    logic [RW-1:0]        r_rt_root [0:RW];
    t_rpay                r_rp      [0:RW];
    logic                 r_rv      [0:RW];

    logic [DV-1:0]        r_dr  [0:NS+1][0:2];
    logic [QB-1:0]        r_dq  [0:NS+1][0:2];
    t_dpay                r_dp  [0:NS+1];
    logic                 r_dvv [0:NS+1];

    t_dpay                n_e_pay;
    logic [DV-1:0]        n_e_r [0:2];
    logic [QB-1:0]        n_e_q [0:2];
    logic [RW:0]          e_sum;
    logic [RW:0]          e_diff;
    logic [RW-1:0]        e_len;

    logic [2:0][NB-1:0]   f_nrm;
    logic                 f_hit;
    logic [DPW-1:0]       f_depth;
    t_dpay                f_pay;

    logic [TB-1:0]        r_o_tag;
    logic [2:0][NB-1:0]   r_o_nrm;
    logic [DPW-1:0]       r_o_depth;

    assign en    = !r_ov || !i_stall;
    assign o_pop = en && !i_empty;

    // Stage A: take the queue head.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (en) begin
            r_va <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= t_qword'(i_word);
        end
    end

    // Stage B: magnitudes, squares and plane products.
    always_comb begin
        logic [DW-1:0] m;
        n_b_pay        = '0;
        n_b_pay.op     = r_a.op;
        n_b_pay.tag    = r_a.tag;
        n_b_pay.sum    = r_a.sum;
        n_b_pay.nrm    = r_a.nrm;
        for (int i = 0; i < 3; i++) begin
            m = r_a.d[i][DW-1] ? DW'(-$signed(r_a.d[i])) : r_a.d[i];
            n_b_pay.sgn[i] = r_a.d[i][DW-1];
            n_b_pay.mag[i] = m;
            n_b_sq[i]      = (2*DW)'(m * m);
            n_b_prod[i]    = PW'($signed(r_a.own[i]) * $signed(r_a.nrm[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (en) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_pay  <= n_b_pay;
            r_b_sq   <= n_b_sq;
            r_b_prod <= n_b_prod;
            r_b_size <= r_a.size;
            r_b_rad  <= r_a.rad;
        end
    end

    // Stage C: sum of squares and plane dot product minus scaled offset.
    always_comb begin
        n_c_sq  = SQW'(r_b_sq[0]) + SQW'(r_b_sq[1]) + SQW'(r_b_sq[2]);
        n_c_acc = TW'($signed(r_b_prod[0])) + TW'($signed(r_b_prod[1]))
                + TW'($signed(r_b_prod[2])) - (TW'($signed(r_b_size)) <<< NS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (en) begin
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_pay <= r_b_pay;
            r_c_sq  <= n_c_sq;
            r_c_acc <= n_c_acc;
            r_c_rad <= r_b_rad;
        end
    end

    // Stage D: plane distance and depth, root pipeline entry.
    always_comb begin
        d_dist         = r_c_acc[TW-1:NS];
        d_t            = TTW'({2'b00, r_c_rad}) - TTW'($signed(d_dist));
        n_d_pay        = r_c_pay;
        n_d_pay.phit   = !d_t[TTW-1] && (d_t != '0);
        n_d_pay.pdepth = (d_t[TTW-2:DPW] != '0) ? '1 : d_t[DPW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv[0] <= 1'b0;
        end else if (en) begin
            r_rv[0] <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rt_rad[0]  <= r_c_sq;
            r_rt_rem[0]  <= '0;
            r_rt_root[0] <= '0;
            r_rp[0]      <= n_d_pay;
        end
    end

    // Square root, one result bit per stage.
    for (genvar k = 0; k < RW; k++) begin : g_root
        logic [RMW-1:0] cur;
        logic [RMW-1:0] trial;
        logic           ge;

        always_comb begin
            cur   = {r_rt_rem[k][RMW-3:0], r_rt_rad[k][SQW-1 -: 2]};
            trial = {r_rt_root[k], 2'b01};
            ge    = (cur >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rv[k+1] <= 1'b0;
            end else if (en) begin
                r_rv[k+1] <= r_rv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rt_rad[k+1]  <= {r_rt_rad[k][SQW-3:0], 2'b00};
                r_rt_rem[k+1]  <= ge ? cur - trial : cur;
                r_rt_root[k+1] <= {r_rt_root[k][RW-2:0], ge};
                r_rp[k+1]      <= r_rp[k];
            end
        end
    end

    // Stage E: sphere hit test, depth and divider entry.
    always_comb begin
        logic [RW-1:0] mx;
        logic          q0;
        e_len          = r_rt_root[RW];
        e_sum          = (RW+1)'(r_rp[RW].sum);
        e_diff         = e_sum - {1'b0, e_len};
        n_e_pay.op     = r_rp[RW].op;
        n_e_pay.tag    = r_rp[RW].tag;
        n_e_pay.sgn    = r_rp[RW].sgn;
        n_e_pay.phit   = r_rp[RW].phit;
        n_e_pay.pdepth = r_rp[RW].pdepth;
        n_e_pay.nrm    = r_rp[RW].nrm;
        n_e_pay.shit   = !r_rp[RW].sum[DW-1] && ({1'b0, e_len} < e_sum);
        n_e_pay.sdepth = e_diff[DPW-1:0];
        n_e_pay.zl     = (e_len == '0);
        n_e_pay.len    = e_len;
        for (int i = 0; i < 3; i++) begin
            mx       = RW'(r_rp[RW].mag[i]);
            q0       = (mx >= e_len);
            n_e_r[i] = DV'(q0 ? mx - e_len : mx);
            n_e_q[i] = QB'(q0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv[0] <= 1'b0;
        end else if (en) begin
            r_dvv[0] <= r_rv[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dp[0] <= n_e_pay;
            for (int i = 0; i < 3; i++) begin
                r_dr[0][i] <= n_e_r[i];
                r_dq[0][i] <= n_e_q[i];
            end
        end
    end

    // Normal divider, one quotient bit per stage in three lanes.
    for (genvar j = 0; j <= NS; j++) begin : g_div
        logic [DV-1:0] cur  [0:2];
        logic          ge   [0:2];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                cur[i] = {r_dr[j][i][RW-1:0], 1'b0};
                ge[i]  = (cur[i] >= {1'b0, r_dp[j].len});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvv[j+1] <= 1'b0;
            end else if (en) begin
                r_dvv[j+1] <= r_dvv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dp[j+1] <= r_dp[j];
                for (int i = 0; i < 3; i++) begin
                    r_dr[j+1][i] <= ge[i] ? cur[i] - {1'b0, r_dp[j].len} : cur[i];
                    r_dq[j+1][i] <= {r_dq[j][i][QB-2:0], ge[i]};
                end
            end
        end
    end

    // Final stage: rounding, sign and selection between the two shapes.
    always_comb begin
        logic [QB:0]   qp1;
        logic [NB-1:0] rnd;
        f_pay = r_dp[NS+1];
        for (int i = 0; i < 3; i++) begin
            qp1 = {1'b0, r_dq[NS+1][i]} + 1'b1;
            rnd = NB'(qp1[QB:1]);
            if (f_pay.op == sct_pkg::t_op_plane) begin
                f_nrm[i] = f_pay.nrm[i];
            end else if (f_pay.zl) begin
                f_nrm[i] = '0;
            end else begin
                f_nrm[i] = f_pay.sgn[i] ? NB'(-$signed(rnd)) : rnd;
            end
        end
        f_hit   = (f_pay.op == sct_pkg::t_op_plane) ? f_pay.phit : f_pay.shit;
        f_depth = (f_pay.op == sct_pkg::t_op_plane) ? f_pay.pdepth : f_pay.sdepth;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dvv[NS+1] && f_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_tag   <= f_pay.tag;
            r_o_nrm   <= f_nrm;
            r_o_depth <= f_depth;
        end
    end

    assign o_valid       = r_ov;
    assign o_contact_tag = r_o_tag;
    assign o_normal_x    = r_o_nrm[0];
    assign o_normal_y    = r_o_nrm[1];
    assign o_normal_z    = r_o_nrm[2];
    assign o_depth       = r_o_depth;

endmodule

// ===== design/sphere_contact_test_unit.sv =====
// Sphere contact test unit: one sphere against a sphere or a plane, fully
// pipelined; a new query word may be taken every clock and every query whose
// shapes touch yields one contact word, in query order. No query word is
// taken while o_stall is high. The square root yields one result bit per
// stage and the normal divider one quotient bit per stage. Queries without
// contact produce nothing.
// Depends on sct_pkg, sct_front, sct_queue and sct_back.

module sphere_contact_test_unit #(
    parameter int COORD_BITS  = sct_pkg::COORD_BITS,
    parameter int NORMAL_BITS = sct_pkg::NORMAL_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic [sct_pkg::TAG_BITS-1:0]  i_pair_tag,
    input  logic signed [COORD_BITS-1:0]  i_own_x,
    input  logic signed [COORD_BITS-1:0]  i_own_y,
    input  logic signed [COORD_BITS-1:0]  i_own_z,
    input  logic [COORD_BITS-2:0]         i_own_radius,
    input  logic signed [COORD_BITS-1:0]  i_other_x,
    input  logic signed [COORD_BITS-1:0]  i_other_y,
    input  logic signed [COORD_BITS-1:0]  i_other_z,
    input  logic signed [COORD_BITS-1:0]  i_other_size,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sct_pkg::TAG_BITS-1:0]  o_contact_tag,
    output logic signed [NORMAL_BITS-1:0] o_normal_x,
    output logic signed [NORMAL_BITS-1:0] o_normal_y,
    output logic signed [NORMAL_BITS-1:0] o_normal_z,
    output logic [COORD_BITS:0]           o_depth
);

    localparam int QW = sct_pkg::qword_bits(COORD_BITS, NORMAL_BITS);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    logic [QW-1:0] push_word;
    logic [QW-1:0] pop_word;

    sct_front #(
        .COORD_BITS (COORD_BITS),
        .NORMAL_BITS(NORMAL_BITS),
        .QW         (QW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_pair_tag  (i_pair_tag),
        .i_own_x     (i_own_x),
        .i_own_y     (i_own_y),
        .i_own_z     (i_own_z),
        .i_own_radius(i_own_radius),
        .i_other_x   (i_other_x),
        .i_other_y   (i_other_y),
        .i_other_z   (i_other_z),
        .i_other_size(i_other_size),
        .i_full      (full),
        .o_push      (push),
        .o_word      (push_word)
    );

    sct_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_word),
        .o_full (full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_data (pop_word)
    );

    sct_back #(
        .COORD_BITS (COORD_BITS),
        .NORMAL_BITS(NORMAL_BITS),
        .QW         (QW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_word       (pop_word),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_contact_tag(o_contact_tag),
        .o_normal_x   (o_normal_x),
        .o_normal_y   (o_normal_y),
        .o_normal_z   (o_normal_z),
        .o_depth      (o_depth)
    );

endmodule
